// ===== hw/rtl/coo2cs_pkg.sv =====
`timescale 1ns / 1ps

package coo2cs_pkg;

  localparam int IDX_W  = 12;
  localparam int POS_W  = 16;
  localparam int VAL_W  = 17;
  localparam int MCNT_W = 13;

  // Register index, taken from paddr[2]
  localparam logic REG_COLUMN_MAJOR = 1'b0;
  localparam logic REG_MAJOR_COUNT  = 1'b1;

  typedef enum logic {
    OP_ENTRY  = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_INDEX = 2'd1,
    KIND_DROP  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_ORDER = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   first_pos;
    logic [POS_W-1:0]   last_pos;
    logic [VAL_W-1:0]   value;
    status_t            status;
    logic               done_res;
  } result_t;

endpackage

// ===== hw/rtl/coo2cs_out_fifo.sv =====
`timescale 1ns / 1ps

module coo2cs_out_fifo
  import coo2cs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2 || pop))
    else $error("result queue overflow");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && count == 2'd1) |=> !space)
    else $error("result queue count lost a push");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && count == 2'd1) |=> !out_valid)
    else $error("result queue count lost a pop");

endmodule

// ===== hw/rtl/sorted_coo_to_compressed_sparse.sv =====
`timescale 1ns / 1ps

// Sorted coordinate list to compressed sparse pointers and indices.
// Input stream s_*: one request per entry (s_tuser = op, 0 entry, 1 finish),
// row and column in s_tdata. Output stream m_*: pointer runs, index entries
// and dropped-entry reports; m_tuser is the kind, m_tlast marks the last
// result of a request. APB port: register 0 column_major, register 1
// major_count, to be written by the user only while the stream is idle;
// the block itself does not enforce this. A request is held in the request
// register and its results pass through a two-entry output queue before
// they reach m_tvalid. The request register emits one result per cycle
// while the queue has space: one for an index-only entry, a drop or a
// finish, two (a pointer run, then the index entry) for an entry that
// opens a pointer run. A finish with no slot left to fill emits nothing.
// Reset clears the pointer slot and entry count, sets column_major to 0 and
// major_count to MAX_DIM. When the receiver stalls, the output queue fills,
// the request register holds and s_tready drops; nothing is lost.
module sorted_coo_to_compressed_sparse
  import coo2cs_pkg::*;
#(
  parameter int MAX_DIM = 4096,
  parameter int MAX_NNZ = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // row_index[11:0], col_index[23:12]
  input  logic [0:0]            s_tuser,   // op[0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,   // first_pos, last_pos, value, status, zero pad
  output logic [1:0]            m_tuser,   // kind[1:0]
  output logic                  m_tlast,   // done_res
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int SLOT_W = $clog2(((MAX_DIM < 4096) ? MAX_DIM : 4096) + 1);
  localparam int CNT_W  = $clog2(MAX_NNZ + 1);
  localparam logic [VAL_W-1:0] DIM_CAP = VAL_W'(MAX_DIM);

  // configuration
  logic              column_major;
  logic [MCNT_W-1:0] major_count;
  logic              major_dflt;
  logic              cfg_write;

  // request register
  logic              item_valid;
  op_t               item_op;
  logic [IDX_W-1:0]  item_row;
  logic [IDX_W-1:0]  item_col;

  // conversion state
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic [DIM_W-1:0]  eff;
  logic [VAL_W-1:0]  mc_wide;
  logic [IDX_W-1:0]  major;
  logic [IDX_W-1:0]  minor;
  logic [VAL_W-1:0]  major_wide;
  logic [VAL_W-1:0]  slot_wide;
  logic [VAL_W-1:0]  eff_wide;
  status_t           status;
  result_t           res;
  result_t           out_res;
  logic              has_res;
  logic              last_res;
  logic              space;
  logic              fire;
  logic              advance;
  logic              complete;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_major <= 1'b0;
      major_count  <= MCNT_W'(MAX_DIM);
      major_dflt   <= 1'b1;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_COLUMN_MAJOR: column_major <= pwdata[0];
        REG_MAJOR_COUNT: begin
          major_count <= pwdata[MCNT_W-1:0];
          major_dflt  <= 1'b0;
        end
        default: column_major <= column_major;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COLUMN_MAJOR: prdata = {31'd0, column_major};
      REG_MAJOR_COUNT:  prdata = {{(32 - MCNT_W){1'b0}}, major_count};
      default:          prdata = 32'd0;
    endcase
  end

  // effective major bound, saturated to MAX_DIM
  assign mc_wide = VAL_W'(major_count);
  assign eff     = major_dflt ? DIM_W'(MAX_DIM)
                              : DIM_W'((mc_wide > DIM_CAP) ? DIM_CAP : mc_wide);

  assign major      = column_major ? item_col : item_row;
  assign minor      = column_major ? item_row : item_col;
  assign major_wide = VAL_W'(major);
  assign slot_wide  = VAL_W'(slot);
  assign eff_wide   = VAL_W'(eff);

  always_comb begin
    priority if (major_wide >= eff_wide) begin
      status = STATUS_RANGE;
    end else if (slot != '0 && (major_wide + VAL_W'(1)) < slot_wide) begin
      status = STATUS_ORDER;
    end else if (count >= CNT_W'(MAX_NNZ)) begin
      status = STATUS_FULL;
    end else begin
      status = STATUS_OK;
    end
  end

  // One result per cycle while the output queue has space. A pointer run moves
  // slot past the major index, so the same request then yields its index entry.
  always_comb begin
    res        = '0;
    has_res    = 1'b0;
    last_res   = 1'b0;
    slot_next  = slot;
    count_next = count;
    if (item_op == OP_FINISH) begin
      has_res       = (slot_wide <= eff_wide);
      last_res      = 1'b1;
      res.kind      = KIND_RUN;
      res.first_pos = POS_W'(slot);
      res.last_pos  = POS_W'(eff);
      res.value     = VAL_W'(count);
      res.status    = STATUS_OK;
      res.done_res  = 1'b1;
      slot_next     = '0;
      count_next    = '0;
    end else if (status != STATUS_OK) begin
      has_res      = 1'b1;
      last_res     = 1'b1;
      res.kind     = KIND_DROP;
      res.status   = status;
      res.done_res = 1'b1;
    end else if (slot_wide <= major_wide) begin
      has_res       = 1'b1;
      res.kind      = KIND_RUN;
      res.first_pos = POS_W'(slot);
      res.last_pos  = POS_W'(major);
      res.value     = VAL_W'(count);
      res.status    = STATUS_OK;
      slot_next     = SLOT_W'(major_wide + VAL_W'(1));
    end else begin
      has_res       = 1'b1;
      last_res      = 1'b1;
      res.kind      = KIND_INDEX;
      res.first_pos = POS_W'(count);
      res.last_pos  = POS_W'(count);
      res.value     = VAL_W'(minor);
      res.status    = STATUS_OK;
      res.done_res  = 1'b1;
      count_next    = CNT_W'(count + CNT_W'(1));
    end
  end

  assign fire     = item_valid && has_res && space;
  assign advance  = item_valid && (fire || !has_res);
  assign complete = advance && last_res;
  assign s_tready = !item_valid || complete;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_op  <= op_t'(s_tuser[0]);
      item_row <= s_tdata[IDX_W-1:0];
      item_col <= s_tdata[2*IDX_W-1:IDX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      slot       <= '0;
      count      <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        item_valid <= 1'b1;
      end else if (complete) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        slot  <= slot_next;
        count <= count_next;
      end
    end
  end

  coo2cs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {5'd0, out_res.status, out_res.value, out_res.last_pos,
                    out_res.first_pos};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.done_res;

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (complete && item_op == OP_FINISH) |=> (slot == '0 && count == '0))
    else $error("finish left conversion state behind");

  a_drop_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (fire && res.kind == KIND_DROP) |=> ($stable(slot) && $stable(count)))
    else $error("dropped entry changed conversion state");

  a_drop_status: assert property (@(posedge clk) disable iff (rst)
    (fire && res.kind == KIND_DROP) |-> (res.status != STATUS_OK && res.done_res))
    else $error("dropped entry without status");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_wide <= DIM_CAP)
    else $error("pointer slot beyond MAX_DIM");

endmodule
